// File: src/cfs_pkg.sv
// Shared constants for the complex frequency shifter with detection.
// Used by cfs_trig and complex_frequency_shift_detect.
`timescale 1ns / 1ps

package cfs_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int PHASE_BITS_DEF  = 32;
    localparam int TRIG_BITS_DEF   = 16;

    // phase index width into the quarter-wave polynomial
    localparam int PIDX_BITS = 16;

    // Q30 polynomial coefficients
    localparam logic [30:0] Q30_A = 31'd1686629713;
    localparam logic [29:0] Q30_B = 30'd688904866;
    localparam logic [26:0] Q30_C = 27'd76016977;

    // register indexes
    localparam logic [1:0] REG_PHASE_STEP  = 2'd0;
    localparam logic [1:0] REG_DETECT_MODE = 2'd1;

    // detect modes
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_MAG  = 2'd1;
    localparam logic [1:0] MODE_POW  = 2'd2;

endpackage

// File: src/cfs_trig.sv
// Pipelined sine/cosine generator, five stages, quarter-wave polynomial.
// Depends on cfs_pkg.
`timescale 1ns / 1ps

module cfs_trig #(
    parameter int TRIG_BITS = cfs_pkg::TRIG_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [cfs_pkg::PIDX_BITS-1:0] i_phase,
    output logic signed [TRIG_BITS:0]     o_sin,
    output logic signed [TRIG_BITS:0]     o_cos
);
    import cfs_pkg::*;

    localparam int SH = 31 - TRIG_BITS;

    // lane 0 sine, lane 1 cosine
    logic [14:0] x_sel [2];
    logic        neg_sel [2];
    logic [1:0]  quad [2];

    logic [14:0] r_x1 [2];
    logic [28:0] r_x2a [2];
    logic        r_neg1 [2];

    logic [27:0] r_t [2];
    logic [14:0] r_x2 [2];
    logic [28:0] r_x2b [2];
    logic        r_neg2 [2];

    logic [30:0] r_v [2];
    logic [14:0] r_x3 [2];
    logic        r_neg3 [2];

    logic [31:0] r_y [2];
    logic        r_neg4 [2];

    logic signed [TRIG_BITS:0] r_out [2];

    always_comb begin
        quad[0] = i_phase[15:14];
        quad[1] = i_phase[15:14] + 2'd1;
        for (int k = 0; k < 2; k++) begin
            x_sel[k]   = quad[k][0] ? (15'd16384 - {1'b0, i_phase[13:0]})
                                    : {1'b0, i_phase[13:0]};
            neg_sel[k] = quad[k][1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 2; k++) begin
                logic [29:0] sq;
                logic [55:0] pc;
                logic [29:0] bt;
                logic [58:0] pb;
                logic [30:0] w;
                logic [45:0] pa;
                logic signed [33:0] ys;
                logic signed [33:0] rs;
                sq = x_sel[k] * x_sel[k];
                r_x1[k]   <= x_sel[k];
                r_x2a[k]  <= sq[28:0];
                r_neg1[k] <= neg_sel[k];

                pc = Q30_C * r_x2a[k];
                r_t[k]    <= pc[55:28];
                r_x2[k]   <= r_x1[k];
                r_x2b[k]  <= r_x2a[k];
                r_neg2[k] <= r_neg1[k];

                bt = Q30_B - {2'b00, r_t[k]};
                pb = bt * r_x2b[k];
                r_v[k]    <= pb[58:28];
                r_x3[k]   <= r_x2[k];
                r_neg3[k] <= r_neg2[k];

                w  = Q30_A - r_v[k];
                pa = w * r_x3[k];
                r_y[k]    <= pa[45:14];
                r_neg4[k] <= r_neg3[k];

                ys = r_neg4[k] ? -$signed({2'b00, r_y[k]}) : $signed({2'b00, r_y[k]});
                rs = (ys + $signed(34'd1 << (SH - 1))) >>> SH;
                r_out[k] <= rs[TRIG_BITS:0];
            end
        end
    end

    assign o_sin = r_out[0];
    assign o_cos = r_out[1];

endmodule

// File: src/cfs_sqrt_cell.sv
// One cell of the digit-by-digit square root chain: one root bit per cell.
// Does not use cfs_pkg; its widths come from the PW and RB parameters.
`timescale 1ns / 1ps

module cfs_sqrt_cell #(
    parameter int PW = 34,
    parameter int RB = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [PW-1:0] i_n,
    input  logic [RB+1:0] i_rem,
    input  logic [RB-1:0] i_root,
    output logic          o_valid,
    output logic [PW-1:0] o_n,
    output logic [RB+1:0] o_rem,
    output logic [RB-1:0] o_root
);
    logic [RB+1:0] rem_sh;
    logic [RB+1:0] trial;
    logic          take;

    logic          r_valid;
    logic [PW-1:0] r_n;
    logic [RB+1:0] r_rem;
    logic [RB-1:0] r_root;

    assign rem_sh = {i_rem[RB-1:0], i_n[PW-1:PW-2]};
    assign trial  = {i_root, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n    <= {i_n[PW-3:0], 2'b00};
            r_rem  <= take ? rem_sh - trial : rem_sh;
            r_root <= {i_root[RB-2:0], take};
        end
    end

    assign o_valid = r_valid;
    assign o_n     = r_n;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

endmodule

// File: src/complex_frequency_shift_detect.sv
// Top level: phase accumulator, complex rotation, power and magnitude detect.
// Depends on cfs_pkg, cfs_trig and cfs_sqrt_cell.
//
// Usage:
//   Sample channel: i_valid / o_stall with i_sample_real, i_sample_imag.
//   Result channel: o_valid / i_stall with o_out_real, o_out_imag,
//   o_detected. Config: i_cfg_valid / o_cfg_ready (always ready), index
//   0 phase_step, 1 detect_mode; other indexes are ignored.
//   From the accepting edge the input stage loads, then five trig stages,
//   two rotation stages, two power stages, SAMPLE_BITS+1 square root cells
//   and the output register follow. One beat per cycle sustained while
//   the receiver does not stall; every stage moves together.
//   The first sample after reset is rotated by angle zero; the phase
//   accumulator advances by phase_step on every accepted beat.
//   Reset clears the accumulator, both registers and all valid flags.
//   While the receiver stalls a held result, the whole chain freezes and
//   o_stall goes high.
`timescale 1ns / 1ps

module complex_frequency_shift_detect #(
    parameter int SAMPLE_BITS = cfs_pkg::SAMPLE_BITS_DEF,
    parameter int PHASE_BITS  = cfs_pkg::PHASE_BITS_DEF,
    parameter int TRIG_BITS   = cfs_pkg::TRIG_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_real,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_imag,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS:0]   o_out_real,
    output logic signed [SAMPLE_BITS:0]   o_out_imag,
    output logic [31:0]                   o_detected,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import cfs_pkg::*;

    localparam int OW  = SAMPLE_BITS + 2;          // internal rotated width
    localparam int PRW = SAMPLE_BITS + TRIG_BITS + 1;
    localparam int PW  = 2 * SAMPLE_BITS + 2;      // power width
    localparam int RB  = PW / 2;                   // root bits
    localparam int NPRE = 10;                      // stages ahead of sqrt chain
    localparam logic [63:0] LIMIT = (2 * SAMPLE_BITS - 1 >= 32) ? 64'hFFFF_FFFF
                                  : (64'd1 << (2 * SAMPLE_BITS - 1));

    logic en;
    logic r_out_valid;

    assign en          = !(r_out_valid && i_stall);
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    // configuration and phase
    logic [31:0]           r_phase_step;
    logic [1:0]            r_detect_mode;
    logic [PHASE_BITS-1:0] r_acc;
    logic [PHASE_BITS+31:0] step_wide;
    logic [PHASE_BITS-1:0] step_ext;

    assign step_wide = {{PHASE_BITS{1'b0}}, r_phase_step};
    assign step_ext  = step_wide[PHASE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step  <= '0;
            r_detect_mode <= MODE_NONE;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_PHASE_STEP) begin
                r_phase_step <= i_cfg_data;
            end else if (i_cfg_index == REG_DETECT_MODE) begin
                r_detect_mode <= i_cfg_data[1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_valid && en) begin
            r_acc <= r_acc + step_ext;
        end
    end

    // valid chain through the pre-sqrt stages
    logic [NPRE-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NPRE-2:0], i_valid};
        end
    end

    // stage 1: capture; stages 2..6 carry samples alongside trig
    logic signed [SAMPLE_BITS-1:0] r_re [6];
    logic signed [SAMPLE_BITS-1:0] r_im [6];
    logic [1:0]                    r_md [10];
    logic [PIDX_BITS-1:0]          r_p;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_re[0] <= i_sample_real;
            r_im[0] <= i_sample_imag;
            r_md[0] <= r_detect_mode;
            r_p     <= r_acc[PHASE_BITS-1 -: PIDX_BITS];
            for (int k = 1; k < 6; k++) begin
                r_re[k] <= r_re[k-1];
                r_im[k] <= r_im[k-1];
            end
            for (int k = 1; k < 10; k++) begin
                r_md[k] <= r_md[k-1];
            end
        end
    end

    logic signed [TRIG_BITS:0] sin_v;
    logic signed [TRIG_BITS:0] cos_v;

    cfs_trig #(.TRIG_BITS(TRIG_BITS)) u_trig (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_phase (r_p),
        .o_sin   (sin_v),
        .o_cos   (cos_v)
    );

    // stage 7: products, stage 8: rounded rotation
    logic signed [PRW-1:0] r_rc, r_is, r_rs, r_ic;
    logic signed [OW-1:0]  r_ore, r_oim;
    logic signed [PRW:0]   sum_re, sum_im, rnd_re, rnd_im;

    assign sum_re = $signed({r_rc[PRW-1], r_rc}) - $signed({r_is[PRW-1], r_is})
                  + $signed((PRW+1)'(1) << (TRIG_BITS - 2));
    assign sum_im = $signed({r_rs[PRW-1], r_rs}) + $signed({r_ic[PRW-1], r_ic})
                  + $signed((PRW+1)'(1) << (TRIG_BITS - 2));
    assign rnd_re = sum_re >>> (TRIG_BITS - 1);
    assign rnd_im = sum_im >>> (TRIG_BITS - 1);

    // stage 9: squares, stage 10: power
    logic signed [2*OW-1:0] sq_re, sq_im;
    logic [PW-1:0]          r_sqr, r_sqi, r_pow;
    logic signed [OW-1:0]   r_ore2, r_oim2;

    assign sq_re = r_ore * r_ore;
    assign sq_im = r_oim * r_oim;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rc  <= PRW'(r_re[5] * cos_v);
            r_is  <= PRW'(r_im[5] * sin_v);
            r_rs  <= PRW'(r_re[5] * sin_v);
            r_ic  <= PRW'(r_im[5] * cos_v);
            r_ore <= rnd_re[OW-1:0];
            r_oim <= rnd_im[OW-1:0];
            r_sqr  <= sq_re[PW-1:0];
            r_sqi  <= sq_im[PW-1:0];
            r_ore2 <= r_ore;
            r_oim2 <= r_oim;
            r_pow  <= r_sqr + r_sqi;
        end
    end

    // hold ore/oim one more stage to align with r_pow
    logic signed [OW-1:0] r_ore3, r_oim3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ore3 <= r_ore2;
            r_oim3 <= r_oim2;
        end
    end

    // square root chain with side registers per cell
    logic          c_vld  [RB+1];
    logic [PW-1:0] c_n    [RB+1];
    logic [RB+1:0] c_rem  [RB+1];
    logic [RB-1:0] c_root [RB+1];

    logic signed [OW-1:0] r_s_re  [RB+1];
    logic signed [OW-1:0] r_s_im  [RB+1];
    logic [1:0]           r_s_md  [RB+1];
    logic [PW-1:0]        r_s_pow [RB+1];

    assign c_vld[0]  = r_vld[NPRE-1];
    assign c_n[0]    = r_pow;
    assign c_rem[0]  = '0;
    assign c_root[0] = '0;

    always_comb begin
        r_s_re[0]  = r_ore3;
        r_s_im[0]  = r_oim3;
        r_s_md[0]  = r_md[9];
        r_s_pow[0] = r_pow;
    end

    for (genvar g = 0; g < RB; g++) begin : g_cell
        cfs_sqrt_cell #(.PW(PW), .RB(RB)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_vld[g]),
            .i_n     (c_n[g]),
            .i_rem   (c_rem[g]),
            .i_root  (c_root[g]),
            .o_valid (c_vld[g+1]),
            .o_n     (c_n[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_root  (c_root[g+1])
        );

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s_re[g+1]  <= r_s_re[g];
                r_s_im[g+1]  <= r_s_im[g];
                r_s_md[g+1]  <= r_s_md[g];
                r_s_pow[g+1] <= r_s_pow[g];
            end
        end
    end

    // final rounding, mode select and saturation
    logic [RB:0]   mag;
    logic [63:0]   det_full;
    logic [63:0]   det_sat;
    logic [31:0]   r_det;
    logic signed [SAMPLE_BITS:0] r_o_re, r_o_im;

    assign mag = (c_rem[RB] > {2'b00, c_root[RB]}) ? {1'b0, c_root[RB]} + 1'b1
                                                    : {1'b0, c_root[RB]};

    always_comb begin
        priority if (r_s_md[RB] == MODE_MAG) begin
            det_full = 64'(mag);
        end else if (r_s_md[RB] == MODE_POW) begin
            det_full = 64'(r_s_pow[RB]);
        end else begin
            det_full = '0;
        end
        det_sat = (det_full > LIMIT) ? LIMIT : det_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= c_vld[RB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_re <= r_s_re[RB][SAMPLE_BITS:0];
            r_o_im <= r_s_im[RB][SAMPLE_BITS:0];
            r_det  <= det_sat[31:0];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_real = r_o_re;
    assign o_out_imag = r_o_im;
    assign o_detected = r_det;

endmodule
